FILE: design/ptb_pkg.sv
// ptb_pkg: constants, node word type and saturating count helper for the palindromic tree builder
// no dependencies
`timescale 1ns / 1ps

package ptb_pkg;

  localparam int MAX_NODES   = 4096;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = 12;
  localparam int LEN_W       = 13;
  localparam int SYM_W       = 5;
  localparam int CNT_W       = 12;
  localparam int CHILD_DEPTH = MAX_NODES * ALPHABET + MAX_NODES;
  localparam int CADDR_W     = $clog2(CHILD_DEPTH);
  localparam int TXT_BASE    = MAX_NODES * ALPHABET;

  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_PROP    = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0]       link;
    logic signed [LEN_W-1:0] len;
    logic [CNT_W-1:0]        cnt;
    logic [NODE_W-1:0]       parent;
    logic [SYM_W-1:0]        sym;
  } node_word_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

FILE: design/palindromic_tree_builder_top.sv
// palindromic_tree_builder_top: eertree builder over a symbol stream, one result per request
// append: suffix-link walk (WSTART, WEVAL, WTXT) then edge lookup (CREAD, CCHK), second walk on create
// propagate: PSTART, PLINK, PSUM per node; read: RREAD (skipped for a root or out of range)
// throughput: one request at a time, set by the suffix-link walk through the two memories
// reset: synchronous active low, roots kept in registers; memories need no clearing since
// edges are checked against the parent and symbol stored with each node; uses ptb_pkg
`timescale 1ns / 1ps

module palindromic_tree_builder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind,
  input  logic [ptb_pkg::SYM_W-1:0]         in_symbol,
  input  logic [ptb_pkg::NODE_W-1:0]        in_node_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ptb_pkg::NODE_W-1:0]        out_node,
  output logic signed [ptb_pkg::LEN_W-1:0]  out_pal_length,
  output logic [ptb_pkg::NODE_W-1:0]        out_suffix_node,
  output logic [ptb_pkg::CNT_W-1:0]         out_occurrences,
  output logic                              out_created,
  output logic                              out_full_res
);
  import ptb_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_WSTART = 4'd1;
  localparam logic [3:0] ST_WEVAL  = 4'd2;
  localparam logic [3:0] ST_WTXT   = 4'd3;
  localparam logic [3:0] ST_CREAD  = 4'd4;
  localparam logic [3:0] ST_CCHK   = 4'd5;
  localparam logic [3:0] ST_PSTART = 4'd6;
  localparam logic [3:0] ST_PLINK  = 4'd7;
  localparam logic [3:0] ST_PSUM   = 4'd8;
  localparam logic [3:0] ST_RREAD  = 4'd9;

  localparam logic [CADDR_W-1:0] TXT_ADDR  = CADDR_W'(TXT_BASE);
  localparam logic [CADDR_W-1:0] ALPH_C    = CADDR_W'(ALPHABET);
  localparam logic [LEN_W-1:0]   FULL_LEN  = LEN_W'(MAX_NODES - 2);

  // memories
  node_word_t        nm_mem [MAX_NODES];
  logic [NODE_W-1:0] cm_mem [CHILD_DEPTH];
  node_word_t        nm_rdata_r;
  logic [NODE_W-1:0] cm_rdata_r;
  logic              nm_we, cm_we;
  logic [NODE_W-1:0] nm_raddr, nm_waddr;
  node_word_t        nm_wdata;
  logic [CADDR_W-1:0] cm_raddr, cm_waddr;
  logic [NODE_W-1:0] cm_wdata;

  always_ff @(posedge clk) begin
    if (nm_we) begin
      nm_mem[nm_waddr] <= nm_wdata;
    end
    nm_rdata_r <= nm_mem[nm_raddr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cm_mem[cm_waddr] <= cm_wdata;
    end
    cm_rdata_r <= cm_mem[cm_raddr];
  end

  // control and datapath registers
  logic [3:0]              state_r, state_nxt;
  logic [NODE_W-1:0]       x_r, x_nxt;
  logic                    phase_r, phase_nxt;
  logic [SYM_W-1:0]        sym_r, sym_nxt;
  logic [NODE_W-1:0]       pos_r, pos_nxt;
  logic [NODE_W-1:0]       p_r, p_nxt;
  logic signed [LEN_W-1:0] p_len_r, p_len_nxt;
  logic [NODE_W-1:0]       p_link_r, p_link_nxt;
  logic signed [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [NODE_W-1:0]       cur_link_r, cur_link_nxt;
  logic [NODE_W-1:0]       q_c_r, q_c_nxt;
  logic [NODE_W-1:0]       n_r, n_nxt;
  logic [CNT_W-1:0]        cn_r, cn_nxt;
  logic [CNT_W-1:0]        c0_r, c0_nxt;
  logic [CNT_W-1:0]        c1_r, c1_nxt;
  logic [LEN_W-1:0]        total_r, total_nxt;
  logic [NODE_W-1:0]       last_r, last_nxt;
  logic [LEN_W-1:0]        tlen_r, tlen_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]       o_node_r, o_node_nxt;
  logic signed [LEN_W-1:0] o_len_r, o_len_nxt;
  logic [NODE_W-1:0]       o_link_r, o_link_nxt;
  logic [CNT_W-1:0]        o_cnt_r, o_cnt_nxt;
  logic                    o_created_r, o_created_nxt;
  logic                    o_full_r, o_full_nxt;

  // step helpers
  logic                    emit;
  logic [NODE_W-1:0]       e_node;
  logic signed [LEN_W-1:0] e_len;
  logic [NODE_W-1:0]       e_link;
  logic [CNT_W-1:0]        e_cnt;
  logic                    e_created, e_full;
  logic                    do_found, do_miss, do_hit, do_create;
  logic signed [LEN_W-1:0] f_len;
  logic [NODE_W-1:0]       f_link;
  logic [NODE_W-1:0]       create_link;
  logic signed [LEN_W-1:0] w_len;
  logic [NODE_W-1:0]       w_link;
  logic signed [LEN_W:0]   bpos;
  logic [LEN_W-1:0]        total_m1;
  node_word_t              w;
  logic                    accept;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign total_m1 = total_r - LEN_W'(1);

  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    phase_nxt    = phase_r;
    sym_nxt      = sym_r;
    pos_nxt      = pos_r;
    p_nxt        = p_r;
    p_len_nxt    = p_len_r;
    p_link_nxt   = p_link_r;
    cur_len_nxt  = cur_len_r;
    cur_link_nxt = cur_link_r;
    q_c_nxt      = q_c_r;
    n_nxt        = n_r;
    cn_nxt       = cn_r;
    c0_nxt       = c0_r;
    c1_nxt       = c1_r;
    total_nxt    = total_r;
    last_nxt     = last_r;
    tlen_nxt     = tlen_r;

    out_valid_nxt = out_valid_r && !out_ready;
    o_node_nxt    = o_node_r;
    o_len_nxt     = o_len_r;
    o_link_nxt    = o_link_r;
    o_cnt_nxt     = o_cnt_r;
    o_created_nxt = o_created_r;
    o_full_nxt    = o_full_r;

    nm_we    = 1'b0;
    nm_waddr = '0;
    nm_wdata = '0;
    nm_raddr = x_r;
    cm_we    = 1'b0;
    cm_waddr = '0;
    cm_wdata = '0;
    cm_raddr = '0;

    emit        = 1'b0;
    e_node      = '0;
    e_len       = '0;
    e_link      = '0;
    e_cnt       = '0;
    e_created   = 1'b0;
    e_full      = 1'b0;
    do_found    = 1'b0;
    do_miss     = 1'b0;
    do_hit      = 1'b0;
    do_create   = 1'b0;
    f_len       = '0;
    f_link      = '0;
    create_link = '0;
    w_len       = '0;
    w_link      = '0;
    bpos        = '0;
    w           = nm_rdata_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_APPEND: begin
              if (tlen_r >= FULL_LEN) begin
                emit   = 1'b1;
                e_full = 1'b1;
              end else if ({27'b0, in_symbol} >= ALPHABET) begin
                emit = 1'b1;
              end else begin
                cm_we     = 1'b1;
                cm_waddr  = TXT_ADDR + CADDR_W'(tlen_r[NODE_W-1:0]);
                cm_wdata  = NODE_W'(in_symbol);
                sym_nxt   = in_symbol;
                pos_nxt   = tlen_r[NODE_W-1:0];
                x_nxt     = last_r;
                phase_nxt = 1'b0;
                state_nxt = ST_WSTART;
              end
            end
            KIND_PROP: begin
              n_nxt     = total_m1[NODE_W-1:0];
              state_nxt = ST_PSTART;
            end
            KIND_READ: begin
              if ({1'b0, in_node_index} < total_r) begin
                if (in_node_index == NODE_W'(0)) begin
                  emit   = 1'b1;
                  e_len  = '0;
                  e_link = NODE_W'(1);
                  e_cnt  = c0_r;
                end else if (in_node_index == NODE_W'(1)) begin
                  emit   = 1'b1;
                  e_node = NODE_W'(1);
                  e_len  = -LEN_W'(1);
                  e_link = NODE_W'(1);
                  e_cnt  = c1_r;
                end else begin
                  nm_raddr  = in_node_index;
                  x_nxt     = in_node_index;
                  state_nxt = ST_RREAD;
                end
              end else begin
                emit = 1'b1;
              end
            end
            KIND_RESTART: begin
              total_nxt = LEN_W'(2);
              last_nxt  = '0;
              tlen_nxt  = '0;
              c0_nxt    = '0;
              c1_nxt    = '0;
              emit      = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_WSTART: begin
        nm_raddr = x_r;
        if (x_r == NODE_W'(1)) begin
          do_found = 1'b1;
          f_len    = -LEN_W'(1);
          f_link   = NODE_W'(1);
        end else begin
          state_nxt = ST_WEVAL;
        end
      end
      ST_WEVAL: begin
        w_len        = (x_r == NODE_W'(0)) ? LEN_W'(0) : nm_rdata_r.len;
        w_link       = (x_r == NODE_W'(0)) ? NODE_W'(1) : nm_rdata_r.link;
        cur_len_nxt  = w_len;
        cur_link_nxt = w_link;
        bpos = $signed({2'b00, pos_r}) - (LEN_W+1)'(1) - {w_len[LEN_W-1], w_len};
        if (bpos[LEN_W]) begin
          x_nxt     = w_link;
          state_nxt = ST_WSTART;
        end else begin
          cm_raddr  = TXT_ADDR + CADDR_W'(bpos[NODE_W-1:0]);
          state_nxt = ST_WTXT;
        end
      end
      ST_WTXT: begin
        if (cm_rdata_r[SYM_W-1:0] == sym_r) begin
          do_found = 1'b1;
          f_len    = cur_len_r;
          f_link   = cur_link_r;
        end else begin
          x_nxt     = cur_link_r;
          state_nxt = ST_WSTART;
        end
      end
      ST_CREAD: begin
        q_c_nxt = cm_rdata_r;
        if (cm_rdata_r >= NODE_W'(2) && {1'b0, cm_rdata_r} < total_r) begin
          nm_raddr  = cm_rdata_r;
          state_nxt = ST_CCHK;
        end else begin
          do_miss = 1'b1;
        end
      end
      ST_CCHK: begin
        if (nm_rdata_r.parent == x_r && nm_rdata_r.sym == sym_r) begin
          do_hit = 1'b1;
        end else begin
          do_miss = 1'b1;
        end
      end
      ST_PSTART: begin
        nm_raddr = n_r;
        if (n_r == NODE_W'(1)) begin
          c1_nxt = sat_add(c1_r, c1_r);
          n_nxt  = '0;
        end else if (n_r == NODE_W'(0)) begin
          c1_nxt    = sat_add(c1_r, c0_r);
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PLINK;
        end
      end
      ST_PLINK: begin
        if (nm_rdata_r.link == NODE_W'(0)) begin
          c0_nxt    = sat_add(c0_r, nm_rdata_r.cnt);
          n_nxt     = n_r - NODE_W'(1);
          state_nxt = ST_PSTART;
        end else if (nm_rdata_r.link == NODE_W'(1)) begin
          c1_nxt    = sat_add(c1_r, nm_rdata_r.cnt);
          n_nxt     = n_r - NODE_W'(1);
          state_nxt = ST_PSTART;
        end else begin
          nm_raddr  = nm_rdata_r.link;
          x_nxt     = nm_rdata_r.link;
          cn_nxt    = nm_rdata_r.cnt;
          state_nxt = ST_PSUM;
        end
      end
      ST_PSUM: begin
        w.cnt     = sat_add(nm_rdata_r.cnt, cn_r);
        nm_we     = 1'b1;
        nm_waddr  = x_r;
        nm_wdata  = w;
        n_nxt     = n_r - NODE_W'(1);
        state_nxt = ST_PSTART;
      end
      ST_RREAD: begin
        emit      = 1'b1;
        e_node    = x_r;
        e_len     = nm_rdata_r.len;
        e_link    = nm_rdata_r.link;
        e_cnt     = nm_rdata_r.cnt;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // walk found its node: look up the edge for the new symbol
    if (do_found) begin
      cm_raddr  = CADDR_W'(x_r) * ALPH_C + CADDR_W'(sym_r);
      state_nxt = ST_CREAD;
      if (!phase_r) begin
        p_nxt      = x_r;
        p_len_nxt  = f_len;
        p_link_nxt = f_link;
      end
    end

    if (do_hit) begin
      if (!phase_r) begin
        w.cnt     = (nm_rdata_r.cnt == {CNT_W{1'b1}}) ? nm_rdata_r.cnt
                                                     : nm_rdata_r.cnt + CNT_W'(1);
        nm_we     = 1'b1;
        nm_waddr  = q_c_r;
        nm_wdata  = w;
        emit      = 1'b1;
        e_node    = q_c_r;
        e_len     = nm_rdata_r.len;
        e_link    = nm_rdata_r.link;
        e_cnt     = w.cnt;
        last_nxt  = q_c_r;
        tlen_nxt  = LEN_W'(pos_r) + LEN_W'(1);
        state_nxt = ST_IDLE;
      end else begin
        do_create   = 1'b1;
        create_link = q_c_r;
      end
    end

    if (do_miss) begin
      if (!phase_r) begin
        x_nxt     = p_link_r;
        phase_nxt = 1'b1;
        state_nxt = ST_WSTART;
      end else begin
        do_create   = 1'b1;
        create_link = '0;
      end
    end

    if (do_create) begin
      nm_we           = 1'b1;
      nm_waddr        = total_r[NODE_W-1:0];
      nm_wdata.link   = create_link;
      nm_wdata.len    = p_len_r + LEN_W'(2);
      nm_wdata.cnt    = CNT_W'(1);
      nm_wdata.parent = p_r;
      nm_wdata.sym    = sym_r;
      cm_we           = 1'b1;
      cm_waddr        = CADDR_W'(p_r) * ALPH_C + CADDR_W'(sym_r);
      cm_wdata        = total_r[NODE_W-1:0];
      total_nxt       = total_r + LEN_W'(1);
      emit            = 1'b1;
      e_node          = total_r[NODE_W-1:0];
      e_len           = p_len_r + LEN_W'(2);
      e_link          = create_link;
      e_cnt           = CNT_W'(1);
      e_created       = 1'b1;
      last_nxt        = total_r[NODE_W-1:0];
      tlen_nxt        = LEN_W'(pos_r) + LEN_W'(1);
      state_nxt       = ST_IDLE;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      o_node_nxt    = e_node;
      o_len_nxt     = e_len;
      o_link_nxt    = e_link;
      o_cnt_nxt     = e_cnt;
      o_created_nxt = e_created;
      o_full_nxt    = e_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      c0_r        <= '0;
      c1_r        <= '0;
      total_r     <= LEN_W'(2);
      last_r      <= '0;
      tlen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      c0_r        <= c0_nxt;
      c1_r        <= c1_nxt;
      total_r     <= total_nxt;
      last_r      <= last_nxt;
      tlen_r      <= tlen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    sym_r       <= sym_nxt;
    pos_r       <= pos_nxt;
    p_r         <= p_nxt;
    p_len_r     <= p_len_nxt;
    p_link_r    <= p_link_nxt;
    cur_len_r   <= cur_len_nxt;
    cur_link_r  <= cur_link_nxt;
    q_c_r       <= q_c_nxt;
    n_r         <= n_nxt;
    cn_r        <= cn_nxt;
    o_node_r    <= o_node_nxt;
    o_len_r     <= o_len_nxt;
    o_link_r    <= o_link_nxt;
    o_cnt_r     <= o_cnt_nxt;
    o_created_r <= o_created_nxt;
    o_full_r    <= o_full_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_node        = o_node_r;
  assign out_pal_length  = o_len_r;
  assign out_suffix_node = o_link_r;
  assign out_occurrences = o_cnt_r;
  assign out_created     = o_created_r;
  assign out_full_res    = o_full_r;

endmodule
